// File: rtl/ppmfg_pkg.sv
package ppmfg_pkg;

  // table geometry
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned CHAN_IDX_W   = $clog2(MAX_CHANNELS);
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned SLOT_W       = 12;

  // payload widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PULSE_W  = 9;

  // timing constants in microseconds
  localparam int unsigned SLOT_MAX_US   = 2200;
  localparam int unsigned SYNC_US       = 4500;
  localparam int unsigned PULSE_US      = 300;
  localparam int unsigned GLITCH_US     = 10;
  localparam int unsigned SLOT_MIN_US   = 800;
  localparam int unsigned SLOT_RESET_US = 1500;
  localparam int unsigned COUNT_RESET   = 8;

  // apb register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_ACTIVE_COUNT = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET   = 2'd0,
    REQ_START = 2'd1,
    REQ_TIMER = 2'd2
  } req_t;

  typedef struct packed {
    logic                  en;
    logic [CHAN_IDX_W-1:0] addr;
    logic [SLOT_W-1:0]     data;
  } wr_t;

endpackage

// File: rtl/ppmfg_in_if.sv
interface ppmfg_in_if;
  logic                         valid;
  logic                         ready;
  logic [ppmfg_pkg::REQ_W-1:0]  req_type;
  logic [ppmfg_pkg::IDX_W-1:0]  chan_index;
  logic [ppmfg_pkg::VAL_W-1:0]  chan_value;

  modport source (output valid, output req_type, output chan_index, output chan_value,
                  input ready);
  modport sink   (input valid, input req_type, input chan_index, input chan_value,
                  output ready);
endinterface

// File: rtl/ppmfg_out_if.sv
interface ppmfg_out_if;
  logic                            valid;
  logic                            ready;
  logic [ppmfg_pkg::PERIOD_W-1:0]  slot_period;
  logic [ppmfg_pkg::PULSE_W-1:0]   pulse_width;
  logic                            is_sync_slot;
  logic                            write_accepted;

  modport source (output valid, output slot_period, output pulse_width,
                  output is_sync_slot, output write_accepted, input ready);
  modport sink   (input valid, input slot_period, input pulse_width,
                  input is_sync_slot, input write_accepted, output ready);
endinterface

// File: rtl/ppmfg_table.sv
module ppmfg_table (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [ppmfg_pkg::CHAN_IDX_W-1:0]      rd_addr,
  output logic [ppmfg_pkg::SLOT_W-1:0]          rd_data,
  input  ppmfg_pkg::wr_t                        wr
);

  logic [ppmfg_pkg::SLOT_W-1:0] entry [ppmfg_pkg::MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppmfg_pkg::MAX_CHANNELS; i++) begin
        entry[i] <= ppmfg_pkg::SLOT_W'(ppmfg_pkg::SLOT_RESET_US);
      end
    end else if (wr.en) begin
      entry[wr.addr] <= wr.data;
    end
  end

  assign rd_data = entry[rd_addr];

endmodule

// File: rtl/ppm_frame_generator_unit.sv
// RC PPM frame sequencer. Each beat on in_ch gives exactly one beat on out_ch,
// in order. A set-channel beat (req_type 0) stores chan_value into the 16-entry
// channel table when 800 < value < 2200 and it differs from the stored entry by
// more than 10 us, and reports that in write_accepted. A start beat (1) restarts
// the frame and returns a 4500 us sync period with pulse_width 0. Each timer beat
// (2) returns the next active channel's slot with pulse_width 300, then a sync gap
// that pads the frame to 2200 * channels + 4500 us. Code 3 returns all zeros.
// The channel count is the APB register at byte address 0 (reset 8, register
// values 17 to 31 act as 16); write it only while no beat is in flight. Throughput
// is one beat per clock while out_ch is ready; a beat passes the input register and
// then the result register, with the table read, the slot add and the sync-gap
// subtract between them. Channel table entries reset to 1500 us at once.
module ppm_frame_generator_unit (
  input  logic                              clk,
  input  logic                              rst,
  ppmfg_in_if.sink                          in_ch,
  ppmfg_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppmfg_pkg::PADDR_W-1:0]     paddr,
  input  logic [ppmfg_pkg::PDATA_W-1:0]     pwdata,
  output logic [ppmfg_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  // configuration register
  logic [ppmfg_pkg::COUNT_W-1:0] active_count;

  // input register
  logic                          s1_valid;
  logic [ppmfg_pkg::REQ_W-1:0]   s1_req;
  logic [ppmfg_pkg::IDX_W-1:0]   s1_idx;
  logic [ppmfg_pkg::VAL_W-1:0]   s1_val;

  // result register
  logic                            o_valid;
  logic [ppmfg_pkg::PERIOD_W-1:0]  o_period;
  logic [ppmfg_pkg::PULSE_W-1:0]   o_pulse;
  logic                            o_sync;
  logic                            o_acc;

  // sequencer state
  logic [ppmfg_pkg::COUNT_W-1:0]  slot_ptr, slot_ptr_next;
  logic [ppmfg_pkg::PERIOD_W-1:0] elapsed, elapsed_next;
  logic                           sync_pend, sync_pend_next;

  // result of the item in the input register
  logic [ppmfg_pkg::PERIOD_W-1:0] period_next;
  logic [ppmfg_pkg::PULSE_W-1:0]  pulse_next;
  logic                           sync_next;
  logic                           acc_next;

  logic                             advance;
  logic                             in_beat;
  logic [ppmfg_pkg::COUNT_W-1:0]    count_eff;
  logic [ppmfg_pkg::COUNT_W-1:0]    ptr_eff;
  logic [ppmfg_pkg::PERIOD_W-1:0]   elapsed_eff;
  logic [ppmfg_pkg::PERIOD_W-1:0]   frame_us;
  logic [ppmfg_pkg::CHAN_IDX_W-1:0] rd_addr;
  logic [ppmfg_pkg::SLOT_W-1:0]     rd_data;
  logic [ppmfg_pkg::VAL_W-1:0]      old_val;
  logic [ppmfg_pkg::VAL_W-1:0]      diff;
  logic                             in_range;
  ppmfg_pkg::wr_t                   wr;

  // ---------------------------------------------------------------------------
  // apb register: one register, decoded on paddr[2] only; writes with paddr[2] set are dropped
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ppmfg_pkg::COUNT_W'(ppmfg_pkg::COUNT_RESET);
    end else if (psel && penable && pwrite && paddr[2] == ppmfg_pkg::REG_ACTIVE_COUNT) begin
      active_count <= pwdata[ppmfg_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == ppmfg_pkg::REG_ACTIVE_COUNT) begin
      prdata = ppmfg_pkg::PDATA_W'(active_count);
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: input register moves into the result register whenever that one
  // is empty or being drained, so a beat can be taken every clock
  // ---------------------------------------------------------------------------
  assign advance     = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;
  assign in_beat     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_req <= in_ch.req_type;
      s1_idx <= in_ch.chan_index;
      s1_val <= in_ch.chan_value;
    end
  end

  // ---------------------------------------------------------------------------
  // channel table, one read port shared by set-channel and timer beats
  // ---------------------------------------------------------------------------
  assign count_eff = (active_count > ppmfg_pkg::COUNT_W'(ppmfg_pkg::MAX_CHANNELS))
                   ? ppmfg_pkg::COUNT_W'(ppmfg_pkg::MAX_CHANNELS) : active_count;

  // a pending sync means the next timer beat starts a fresh frame
  assign ptr_eff     = sync_pend ? '0 : slot_ptr;
  assign elapsed_eff = sync_pend ? '0 : elapsed;

  assign rd_addr = (s1_req == ppmfg_pkg::REQ_SET) ? s1_idx[ppmfg_pkg::CHAN_IDX_W-1:0]
                                                   : ptr_eff[ppmfg_pkg::CHAN_IDX_W-1:0];

  ppmfg_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign frame_us = ppmfg_pkg::PERIOD_W'(ppmfg_pkg::SLOT_MAX_US * 32'(count_eff)
                                         + ppmfg_pkg::SYNC_US);

  // anti-glitch filter
  assign old_val  = ppmfg_pkg::VAL_W'(rd_data);
  assign diff     = (old_val > s1_val) ? old_val - s1_val : s1_val - old_val;
  assign in_range = s1_val > ppmfg_pkg::VAL_W'(ppmfg_pkg::SLOT_MIN_US)
                 && s1_val < ppmfg_pkg::VAL_W'(ppmfg_pkg::SLOT_MAX_US);

  always_comb begin
    period_next    = '0;
    pulse_next     = '0;
    sync_next      = 1'b0;
    acc_next       = 1'b0;
    slot_ptr_next  = slot_ptr;
    elapsed_next   = elapsed;
    sync_pend_next = sync_pend;
    wr.en          = 1'b0;
    wr.addr        = s1_idx[ppmfg_pkg::CHAN_IDX_W-1:0];
    wr.data        = s1_val[ppmfg_pkg::SLOT_W-1:0];

    unique case (s1_req)
      ppmfg_pkg::REQ_SET: begin
        if (in_range && diff > ppmfg_pkg::VAL_W'(ppmfg_pkg::GLITCH_US)) begin
          acc_next = 1'b1;
          wr.en    = advance;
        end
      end
      ppmfg_pkg::REQ_START: begin
        slot_ptr_next  = '0;
        elapsed_next   = '0;
        sync_pend_next = 1'b1;
        period_next    = ppmfg_pkg::PERIOD_W'(ppmfg_pkg::SYNC_US);
        sync_next      = 1'b1;
      end
      ppmfg_pkg::REQ_TIMER: begin
        pulse_next = ppmfg_pkg::PULSE_W'(ppmfg_pkg::PULSE_US);
        if (ptr_eff < count_eff) begin
          // next channel slot
          period_next    = ppmfg_pkg::PERIOD_W'(rd_data);
          elapsed_next   = elapsed_eff + ppmfg_pkg::PERIOD_W'(rd_data);
          slot_ptr_next  = ptr_eff + ppmfg_pkg::COUNT_W'(1);
          sync_pend_next = 1'b0;
        end else begin
          // sync gap fills the frame, floored at zero
          period_next    = (frame_us > elapsed_eff) ? frame_us - elapsed_eff : '0;
          sync_next      = 1'b1;
          slot_ptr_next  = ptr_eff;
          elapsed_next   = elapsed_eff;
          sync_pend_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ptr  <= '0;
      elapsed   <= '0;
      sync_pend <= 1'b0;
    end else if (advance) begin
      slot_ptr  <= slot_ptr_next;
      elapsed   <= elapsed_next;
      sync_pend <= sync_pend_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_period <= period_next;
      o_pulse  <= pulse_next;
      o_sync   <= sync_next;
      o_acc    <= acc_next;
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.slot_period    = o_period;
  assign out_ch.pulse_width    = o_pulse;
  assign out_ch.is_sync_slot   = o_sync;
  assign out_ch.write_accepted = o_acc;

endmodule

// File: sim/ppm_frame_generator_unit_test.sv
module ppm_frame_generator_unit_test;
  import ppmfg_pkg::*;

  // request code that the block must answer with all-zero fields
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // run limit in clock cycles, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 200000;
  // settle time after the last owed result, before register writes
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS = 75;

  // one result beat as the block reports it
  typedef struct packed {
    logic [PERIOD_W-1:0] slot_period;
    logic [PULSE_W-1:0]  pulse_width;
    logic                is_sync_slot;
    logic                write_accepted;
  } slot_beat_t;

  logic clk;
  logic rst;

  ppmfg_in_if  in_ch ();
  ppmfg_out_if out_ch ();

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ppm_frame_generator_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the sequencer state, advanced once per accepted request beat
  logic [SLOT_W-1:0]   chan_slot_us [MAX_CHANNELS];
  logic [4:0]          next_slot;
  logic [PERIOD_W-1:0] frame_elapsed_us;
  logic                sync_due;
  logic [COUNT_W-1:0]  chan_count;

  // results still owed by the block, oldest first
  slot_beat_t expected_beats[$];

  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned error_count;
  int unsigned cycle_count;

  // idle and stall chances in percent, zero turns the side fully busy
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // next result of the frame sequencer for one request, updating the shadow state
  function automatic slot_beat_t predict_slot_beat(logic [REQ_W-1:0] req,
                                                   logic [IDX_W-1:0] idx,
                                                   logic [VAL_W-1:0] val);
    slot_beat_t  beat;
    int unsigned count;
    int unsigned stored_us;
    int unsigned req_us;
    int unsigned diff_us;
    int unsigned frame_us;
    beat = '0;
    // counts above the table size act as a full table
    count = (32'(chan_count) > MAX_CHANNELS) ? MAX_CHANNELS : 32'(chan_count);
    case (req)
      REQ_SET: begin
        // a 4-bit index always lands inside the 16-entry table
        stored_us = 32'(chan_slot_us[idx]);
        req_us    = 32'(val);
        if (req_us > SLOT_MIN_US && req_us < SLOT_MAX_US) begin
          diff_us = (stored_us > req_us) ? stored_us - req_us : req_us - stored_us;
          // anti-glitch: small moves keep the old value
          if (diff_us > GLITCH_US) begin
            chan_slot_us[idx]   = val[SLOT_W-1:0];
            beat.write_accepted = 1'b1;
          end
        end
      end
      REQ_START: begin
        next_slot         = '0;
        frame_elapsed_us  = '0;
        sync_due          = 1'b1;
        beat.slot_period  = PERIOD_W'(SYNC_US);
        beat.is_sync_slot = 1'b1;
      end
      REQ_TIMER: begin
        // the first timer after a sync period opens a new frame
        if (sync_due) begin
          sync_due         = 1'b0;
          next_slot        = '0;
          frame_elapsed_us = '0;
        end
        if (32'(next_slot) < count) begin
          beat.slot_period = PERIOD_W'(chan_slot_us[next_slot[CHAN_IDX_W-1:0]]);
          frame_elapsed_us = frame_elapsed_us
                           + PERIOD_W'(chan_slot_us[next_slot[CHAN_IDX_W-1:0]]);
          next_slot        = next_slot + 5'd1;
        end else begin
          // sync gap pads the frame, zero when the frame is already overrun
          frame_us          = SLOT_MAX_US * count + SYNC_US;
          sync_due          = 1'b1;
          beat.slot_period  = (frame_us > 32'(frame_elapsed_us)) ?
                              PERIOD_W'(frame_us - 32'(frame_elapsed_us)) : '0;
          beat.is_sync_slot = 1'b1;
        end
        beat.pulse_width = PULSE_W'(PULSE_US);
      end
      default: ;
    endcase
    return beat;
  endfunction

  // request sender: optional idle burst, then hold the beat until it is taken
  task automatic send_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                              logic [VAL_W-1:0] val);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.chan_index <= idx;
    in_ch.chan_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    expected_beats.push_back(predict_slot_beat(req, idx, val));
  endtask

  // stop sending and let every owed result come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one apb transfer, setup then access phase
  task automatic apb_access(logic write, logic [PADDR_W-1:0] addr,
                            logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // channel count update, only with the block drained, then read back
  task automatic write_channel_count(logic [COUNT_W-1:0] value);
    logic [PADDR_W-1:0] addr;
    logic [PDATA_W-1:0] rdata;
    addr = PADDR_W'(4 * REG_ACTIVE_COUNT);
    wait_for_results();
    apb_access(1'b1, addr, PDATA_W'(value), rdata);
    chan_count = value;
    @(posedge clk);
    apb_access(1'b0, addr, '0, rdata);
    if (rdata !== PDATA_W'(value)) begin
      $error("active_channel_count: expected %0d, got %0d", value, rdata);
      error_count++;
    end
  endtask

  // set-channel values: full range, legal range, near the stored value, limits
  function automatic logic [VAL_W-1:0] pick_chan_value(logic [IDX_W-1:0] idx);
    int unsigned mode;
    int          near_us;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      return VAL_W'($urandom_range(0, 65535));
    end else if (mode < 7) begin
      return VAL_W'($urandom_range(SLOT_MIN_US + 1, SLOT_MAX_US - 1));
    end else if (mode < 9) begin
      near_us = int'(chan_slot_us[idx]) + int'($urandom_range(0, 30)) - 15;
      return VAL_W'(near_us);
    end else begin
      case ($urandom_range(0, 3))
        0: return VAL_W'(SLOT_MIN_US);
        1: return VAL_W'(SLOT_MIN_US + 1);
        2: return VAL_W'(SLOT_MAX_US - 1);
        default: return VAL_W'(SLOT_MAX_US);
      endcase
    end
  endfunction

  // result checker and receiver stall bursts
  always @(posedge clk) begin
    slot_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no request outstanding: period %0d",
               out_ch.slot_period);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        results_checked++;
        if (out_ch.slot_period !== want.slot_period) begin
          $error("slot_period: expected %0d, got %0d", want.slot_period,
                 out_ch.slot_period);
          error_count++;
        end
        if (out_ch.pulse_width !== want.pulse_width) begin
          $error("pulse_width: expected %0d, got %0d", want.pulse_width,
                 out_ch.pulse_width);
          error_count++;
        end
        if (out_ch.is_sync_slot !== want.is_sync_slot) begin
          $error("is_sync_slot: expected %0d, got %0d", want.is_sync_slot,
                 out_ch.is_sync_slot);
          error_count++;
        end
        if (out_ch.write_accepted !== want.write_accepted) begin
          $error("write_accepted: expected %0d, got %0d", want.write_accepted,
                 out_ch.write_accepted);
          error_count++;
        end
      end
    end
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // timer beat straight out of reset, then the unused request code
  task automatic test_reset_sequence();
    send_request(REQ_TIMER, '0, '0);
    send_request(REQ_UNUSED, 4'hf, 16'hffff);
  endtask

  // range limits and the anti-glitch window of the channel table
  task automatic test_channel_writes();
    send_request(REQ_SET, 4'd0, VAL_W'(SLOT_MIN_US));       // at lower limit, rejected
    send_request(REQ_SET, 4'd0, VAL_W'(SLOT_MIN_US + 1));   // just inside, stored
    send_request(REQ_SET, 4'd0, VAL_W'(SLOT_MIN_US + 5));   // glitch, rejected
    send_request(REQ_SET, 4'd15, VAL_W'(SLOT_MAX_US - 1));  // just inside upper limit
    send_request(REQ_SET, 4'd15, VAL_W'(SLOT_MAX_US));      // at upper limit, rejected
    send_request(REQ_SET, 4'd14, 16'hffff);
    send_request(REQ_SET, 4'd13, 16'h0000);
    send_request(REQ_SET, 4'd1, VAL_W'(SLOT_RESET_US + GLITCH_US));      // diff 10
    send_request(REQ_SET, 4'd2, VAL_W'(SLOT_RESET_US - GLITCH_US - 1));  // diff 11
  endtask

  // start, then an empty frame that is all sync gap
  task automatic test_empty_frame();
    send_request(REQ_START, '0, '0);
    write_channel_count('0);
    send_request(REQ_TIMER, '0, '0);
    send_request(REQ_TIMER, '0, '0);
  endtask

  // count lowered in mid frame so the elapsed time exceeds the new frame
  task automatic test_frame_overrun();
    write_channel_count(COUNT_W'(MAX_CHANNELS));
    send_request(REQ_START, '0, '0);
    repeat (4) send_request(REQ_TIMER, '0, '0);
    write_channel_count('0);
    send_request(REQ_TIMER, '0, '0);
  endtask

  // mostly timer beats walking through frames, with table writes, restarts and noise
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned      pick;
    logic [IDX_W-1:0] idx;
    for (int unsigned i = 0; i < n_items; i++) begin
      // hold off once per phase until the block has answered everything
      if (i == n_items / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      idx  = IDX_W'($urandom_range(0, MAX_CHANNELS - 1));
      if (pick < 4) begin
        send_request(REQ_START, idx, VAL_W'($urandom_range(0, 65535)));
      end else if (pick < 7) begin
        send_request(REQ_UNUSED, idx, VAL_W'($urandom_range(0, 65535)));
      end else if (pick < 32) begin
        send_request(REQ_SET, idx, pick_chan_value(idx));
      end else begin
        send_request(REQ_TIMER, idx, VAL_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    int unsigned phase_counts [7];
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = '0;
    in_ch.chan_index = '0;
    in_ch.chan_value = '0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    requests_sent    = 0;
    results_checked  = 0;
    error_count      = 0;
    stall_left       = 0;
    idle_pct         = 30;
    stall_pct        = 30;

    // shadow state matches the block's reset values
    foreach (chan_slot_us[i]) chan_slot_us[i] = SLOT_W'(SLOT_RESET_US);
    next_slot        = '0;
    frame_elapsed_us = '0;
    sync_due         = 1'b0;
    chan_count       = COUNT_W'(COUNT_RESET);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_sequence();
    test_channel_writes();
    test_empty_frame();
    test_frame_overrun();

    // full table, above table size, single channel, empty, just above, random, default
    phase_counts = '{MAX_CHANNELS, 31, 1, 0, MAX_CHANNELS + 1, 0, COUNT_RESET};
    phase_counts[5] = $urandom_range(0, 31);
    foreach (phase_counts[p]) begin
      write_channel_count(COUNT_W'(phase_counts[p]));
      // busy stretches now and then, and none at all in the last phase
      if (p == 6) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = (p % 3 == 2) ? 0 : 30;
        stall_pct = (p % 3 == 1) ? 0 : 30;
      end
      test_random_traffic(PHASE_ITEMS);
    end

    wait_for_results();

    $display("%0d request beats sent, %0d result beats checked", requests_sent,
             results_checked);
    $display("covered table limits, glitch window, frame overrun, counts 0 to 31");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
